/* design/lsp_pkg.sv */
// Shared types and constants for the line sensor position / PID block.
// No dependencies; the top level, lane, PID and testbench files import it.
package lsp_pkg;
	localparam int NUM_SENSORS = 9;
	localparam int SAMPLE_BITS = 10;
	localparam int CAL_W = 10;
	localparam int SUM_W = 14;
	localparam int WSUM_W = 24;
	localparam int QUO_W = 14;
	localparam int CNT_W = 5;

	localparam logic [1:0] REG_GAIN_P = 2'd0;
	localparam logic [1:0] REG_GAIN_I = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;
	localparam logic [1:0] REG_TARGET = 2'd3;

	localparam logic [9:0] TARGET_RESET = 10'd500;
	localparam logic [9:0] POS_MAX = 10'd1000;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] scan_t;
	typedef logic [NUM_SENSORS-1:0][CAL_W-1:0] cal_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_PD, ST_INT, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} lane_ctl_t;
endpackage

/* design/line_sensor_position_pid_top.sv */
// Top level of the line sensor position / PID block.
// Depends on lsp_pkg, lsp_lane and lsp_pid.
//
// Usage: a scan request (nine samples) enters on in_valid/in_stall; one
// result request leaves on out_valid/out_stall. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block does not enforce. Nine lanes calibrate the
// samples in parallel, each with a restoring divider of 21 steps; a merge
// stage sums the readings and weights, the centroid divider takes 24 steps,
// then the PID forms the P and D terms, the integral term and the output.
// Only one scan is in work at a time.
// in_stall is high from acceptance until the result has been taken.
// Reset clears the channel ranges (min 1024, max 0), the integral, the last
// error, the held position, the gains (0) and the target (500).
// While out_stall is high the result holds in its output registers.
module line_sensor_position_pid_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lsp_pkg::sample_t sample_0, input lsp_pkg::sample_t sample_1,
	input  lsp_pkg::sample_t sample_2, input lsp_pkg::sample_t sample_3,
	input  lsp_pkg::sample_t sample_4, input lsp_pkg::sample_t sample_5,
	input  lsp_pkg::sample_t sample_6, input lsp_pkg::sample_t sample_7,
	input  lsp_pkg::sample_t sample_8,
	output logic out_valid,
	input  logic out_stall,
	output logic [9:0] line_position,
	output logic signed [10:0] position_error,
	output logic signed [23:0] drive,
	output logic no_signal,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import lsp_pkg::*;

	scan_t scan;
	cal_vec_t cal;
	logic [NUM_SENSORS-1:0] ldone;
	lane_ctl_t ctl;
	logic busy_q, pid_start_s1;
	logic [WSUM_W-1:0] wsum_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [WSUM_W-1:0] wsum_next;
	logic [SUM_W-1:0] sum_next;
	logic pid_done;
	logic signed [15:0] gp_q, gi_q, gd_q;
	logic [9:0] tgt_q;

	assign scan = {sample_8, sample_7, sample_6, sample_5, sample_4,
		sample_3, sample_2, sample_1, sample_0};
	assign ctl.start = in_valid && !in_stall;
	assign ctl.done = &ldone;
	assign in_stall = busy_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q <= '0; gi_q <= '0; gd_q <= '0; tgt_q <= TARGET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P: gp_q <= cfg_data;
				REG_GAIN_I: gi_q <= cfg_data;
				REG_GAIN_D: gd_q <= cfg_data;
				REG_TARGET: tgt_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_SENSORS; g++) begin : g_lane
			lsp_lane u_lane (.clk(clk), .arst_n(arst_n), .start(ctl.start),
				.sample(scan[g]), .cal(cal[g]), .done(ldone[g]));
		end
	endgenerate

	// Merge the lane readings
	always_comb begin
		logic [WSUM_W-1:0] w;
		logic [SUM_W-1:0] s;
		w = '0; s = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			w = w + WSUM_W'(cal[i]) * WSUM_W'(100 * (i + 1));
			s = s + SUM_W'(cal[i]);
		end
		wsum_next = w; sum_next = s;
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			wsum_s1 <= wsum_next;
			sum_s1 <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; pid_start_s1 <= 1'b0; out_valid <= 1'b0;
		end else begin
			pid_start_s1 <= ctl.done;
			if (ctl.start) busy_q <= 1'b1;
			if (pid_done) out_valid <= 1'b1;
			else if (out_valid && !out_stall) begin
				out_valid <= 1'b0; busy_q <= 1'b0;
			end
		end
	end

	lsp_pid u_pid (.clk(clk), .arst_n(arst_n), .start(pid_start_s1),
		.wsum(wsum_s1), .sum(sum_s1), .gain_p(gp_q), .gain_i(gi_q),
		.gain_d(gd_q), .target(tgt_q), .line_position(line_position),
		.position_error(position_error), .drive(drive),
		.no_signal(no_signal), .done(pid_done));
endmodule

/* design/lsp_lane.sv */
// One calibration lane: running min/max tracking and a restoring divider
// that maps a sample onto 0..1000. Depends on lsp_pkg.
module lsp_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lsp_pkg::sample_t      sample,
	output logic [lsp_pkg::CAL_W-1:0] cal,
	output logic                  done
);
	import lsp_pkg::*;

	logic [SAMPLE_BITS:0]   min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS:0]   nmin;
	logic [SAMPLE_BITS-1:0] nmax;
	logic [SAMPLE_BITS:0]   den_q;
	logic [SAMPLE_BITS+10:0] rem_q;
	logic [CAL_W-1:0]       quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic [SAMPLE_BITS+11:0] trial;
	logic [SAMPLE_BITS+10:0] num;
	logic [SAMPLE_BITS+10:0] nq_q;

	// Update range with the new sample
	always_comb begin
		nmin = ({1'b0, sample} < min_q) ? {1'b0, sample} : min_q;
		nmax = (sample > max_q) ? sample : max_q;
		num = ({10'd0, {1'b0, sample} - nmin}) * 21'(1000);
		trial = {rem_q, nq_q[SAMPLE_BITS+10]} - {11'd0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;
			max_q <= '0;
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				min_q <= nmin;
				max_q <= nmax;
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SAMPLE_BITS + 11)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Long division of (v-min)*1000 by (max-min), one quotient bit a step
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= {1'b0, nmax} - nmin;
			nq_q <= num;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q != CNT_W'(SAMPLE_BITS + 11)) begin
			nq_q <= {nq_q[SAMPLE_BITS+9:0], 1'b0};
			if (!trial[SAMPLE_BITS+11]) begin
				rem_q <= trial[SAMPLE_BITS+10:0];
				quo_q <= {quo_q[CAL_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SAMPLE_BITS+9:0], nq_q[SAMPLE_BITS+10]};
				quo_q <= {quo_q[CAL_W-2:0], 1'b0};
			end
		end
	end

	assign cal = ($signed({1'b0, den_q}) > 0 && !den_q[SAMPLE_BITS]) ? quo_q : '0;
endmodule

/* design/lsp_pid.sv */
// Centroid divider and PID stage with saturating integral.
// Depends on lsp_pkg.
module lsp_pid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [lsp_pkg::WSUM_W-1:0] wsum,
	input  logic [lsp_pkg::SUM_W-1:0]  sum,
	input  logic signed [15:0]     gain_p,
	input  logic signed [15:0]     gain_i,
	input  logic signed [15:0]     gain_d,
	input  logic [9:0]             target,
	output logic [9:0]             line_position,
	output logic signed [10:0]     position_error,
	output logic signed [23:0]     drive,
	output logic                   no_signal,
	output logic                   done
);
	import lsp_pkg::*;

	logic [WSUM_W-1:0] nq_q;
	logic [SUM_W-1:0]  den_q;
	logic [SUM_W:0]    rem_q;
	logic [WSUM_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	state_t            st_q;
	state_t            st_next;
	logic [9:0]        held_q;
	logic signed [10:0] last_q;
	logic signed [31:0] esum_q;
	logic signed [47:0] acc_q;
	logic [SUM_W+1:0]  t;
	logic [9:0]        pos;
	logic signed [10:0] err;
	logic signed [11:0] dif;
	logic signed [32:0] es_w;
	logic signed [31:0] es_sat;
	logic signed [26:0] prod_p;
	logic signed [27:0] prod_d;
	logic signed [47:0] prod_i;
	logic signed [47:0] acc_w;
	logic signed [47:0] drv_w;

	always_comb begin
		t = {rem_q, nq_q[WSUM_W-1]} - {2'd0, den_q};
		if (den_q == '0) pos = held_q;
		else if (quo_q > WSUM_W'(POS_MAX)) pos = POS_MAX;
		else pos = quo_q[9:0];
		err = $signed({1'b0, target}) - $signed({1'b0, pos});
		dif = {err[10], err} - {last_q[10], last_q};
		es_w = 33'(esum_q) + 33'(err);
		if (es_w > 33'sd2147483647) es_sat = 32'sh7fffffff;
		else if (es_w < -33'sd2147483648) es_sat = 32'sh80000000;
		else es_sat = es_w[31:0];
		prod_p = gain_p * err;
		prod_d = gain_d * dif;
		prod_i = gain_i * esum_q;
		acc_w = 48'(prod_p) + 48'(prod_d);
		drv_w = (acc_q < 0) ? -((-acc_q) >>> 8) : (acc_q >>> 8);
	end

	// Next phase: divide, P and D terms, integral term, output
	always_comb begin
		st_next = st_q;
		case (st_q)
			ST_IDLE: if (start) st_next = ST_DIV;
			ST_DIV: if (cnt_q == CNT_W'(WSUM_W - 1)) st_next = ST_PD;
			ST_PD: st_next = ST_INT;
			ST_INT: st_next = ST_OUT;
			ST_OUT: st_next = ST_IDLE;
			default: st_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
			held_q <= '0;
			last_q <= '0;
			esum_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= '0;
			end else if (st_q == ST_DIV) begin
				// divide one bit a step
				cnt_q <= cnt_q + 1'b1;
			end else if (st_q == ST_PD) begin
				// error, integral, P and D terms
				if (den_q != '0) held_q <= pos;
				esum_q <= es_sat;
				last_q <= err;
			end else if (st_q == ST_OUT) begin
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= wsum;
			den_q <= sum;
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == ST_DIV) begin
			nq_q <= {nq_q[WSUM_W-2:0], 1'b0};
			if (!t[SUM_W+1]) begin
				rem_q <= t[SUM_W:0];
				quo_q <= {quo_q[WSUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SUM_W-1:0], nq_q[WSUM_W-1]};
				quo_q <= {quo_q[WSUM_W-2:0], 1'b0};
			end
		end else if (st_q == ST_PD) begin
			line_position <= pos;
			position_error <= err;
			no_signal <= (den_q == '0);
			acc_q <= acc_w;
		end else if (st_q == ST_INT) begin
			acc_q <= acc_q + prod_i;
		end else if (st_q == ST_OUT) begin
			if (drv_w > 48'sd8388607) drive <= 24'sh7fffff;
			else if (drv_w < -48'sd8388608) drive <= 24'sh800000;
			else drive <= drv_w[23:0];
		end
	end
endmodule

/* design/lsp_checker.sv */
// Port-level checks for the line sensor block, bound to the top level.
// Depends on nothing but the top-level ports.
module lsp_checker (
	input logic clk, input logic arst_n, input logic in_valid,
	input logic in_stall, input logic out_valid, input logic out_stall,
	input logic [9:0] line_position
);
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("no stall after request");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_position <= 10'd1000) else $error("position range");
endmodule

bind line_sensor_position_pid_top lsp_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .line_position(line_position));

/* tb/sv/testbench.sv */
// Testbench for line_sensor_position_pid_top: random and directed sensor scans,
// checked against an in-file predictor of calibration, centroid and PID.
// Depends on lsp_pkg and the block's RTL.
class pid_scoreboard;
	int unsigned lo_val[9];
	int unsigned hi_val[9];
	int last_err;
	int err_sum;
	int unsigned held_pos;
	int gp, gi, gd;
	int unsigned target;
	logic [9:0] exp_pos[$];
	logic [10:0] exp_err[$];
	logic [23:0] exp_drive[$];
	logic exp_nosig[$];
	int mismatches;

	function new();
		for (int i = 0; i < 9; i++) begin
			lo_val[i] = 1024;
			hi_val[i] = 0;
		end
		last_err = 0;
		err_sum = 0;
		held_pos = 0;
		gp = 0;
		gi = 0;
		gd = 0;
		target = 500;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			lsp_pkg::REG_GAIN_P: gp = $signed(val);
			lsp_pkg::REG_GAIN_I: gi = $signed(val);
			lsp_pkg::REG_GAIN_D: gd = $signed(val);
			lsp_pkg::REG_TARGET: target = val[9:0];
			default: ;
		endcase
	endfunction

	// Predict the result of one accepted scan
	function void note_scan(int unsigned s[9]);
		longint unsigned wsum, total, c;
		int unsigned pos;
		logic nosig;
		int e, d;
		longint acc, sum64, drv;
		wsum = 0;
		total = 0;
		for (int i = 0; i < 9; i++) begin
			if (s[i] < lo_val[i]) lo_val[i] = s[i];
			if (s[i] > hi_val[i]) hi_val[i] = s[i];
			c = 0;
			if (hi_val[i] > lo_val[i])
				c = (s[i] - lo_val[i]) * 1000 / (hi_val[i] - lo_val[i]);
			wsum += c * 100 * (i + 1);
			total += c;
		end
		if (total == 0) begin
			pos = held_pos;
			nosig = 1;
		end else begin
			pos = wsum / total;
			if (pos > 1000) pos = 1000;
			held_pos = pos;
			nosig = 0;
		end
		e = int'(target) - int'(pos);
		d = e - last_err;
		sum64 = longint'(err_sum) + e;
		if (sum64 > 64'sd2147483647) sum64 = 64'sd2147483647;
		if (sum64 < -64'sd2147483648) sum64 = -64'sd2147483648;
		err_sum = int'(sum64);
		last_err = e;
		acc = longint'(gp) * e + longint'(gi) * err_sum + longint'(gd) * d;
		drv = acc / 256;
		if (drv > 8388607) drv = 8388607;
		if (drv < -8388608) drv = -8388608;
		exp_pos.push_back(pos[9:0]);
		exp_err.push_back(e[10:0]);
		exp_drive.push_back(drv[23:0]);
		exp_nosig.push_back(nosig);
	endfunction

	function void check_result(logic [9:0] pos, logic [10:0] e, logic [23:0] drv, logic ns);
		logic [9:0] xp;
		logic [10:0] xe;
		logic [23:0] xd;
		logic xn;
		if (exp_pos.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result pos=%0d", pos);
			return;
		end
		xp = exp_pos.pop_front();
		xe = exp_err.pop_front();
		xd = exp_drive.pop_front();
		xn = exp_nosig.pop_front();
		if (xp !== pos || xe !== e || xd !== drv || xn !== ns) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp pos=%0d err=%0d drive=%0d ns=%0b, got %0d %0d %0d %0b",
					xp, $signed(xe), $signed(xd), xn, pos, $signed(e), $signed(drv), ns);
		end
	endfunction

	function int pending();
		return exp_pos.size();
	endfunction
endclass

module testbench;
	import lsp_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	sample_t smp[9];
	logic out_valid;
	logic out_stall;
	logic [9:0] line_position;
	logic signed [10:0] position_error;
	logic signed [23:0] drive;
	logic no_signal;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	pid_scoreboard board;
	int unsigned cycles;
	int unsigned stall_mode = 1;

	line_sensor_position_pid_top uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sample_0(smp[0]), .sample_1(smp[1]), .sample_2(smp[2]),
		.sample_3(smp[3]), .sample_4(smp[4]), .sample_5(smp[5]),
		.sample_6(smp[6]), .sample_7(smp[7]), .sample_8(smp[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.line_position(line_position), .position_error(position_error),
		.drive(drive), .no_signal(no_signal),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Check results and bound the run
	always @(posedge clk) begin
		cycles++;
		if (arst_n && out_valid && !out_stall)
			board.check_result(line_position, position_error, drive, no_signal);
		if (cycles > 1500000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stall the result side on a pattern of its own
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// Send one scan request; wait until it is taken
	task automatic send_scan(int unsigned s[9]);
		@(negedge clk);
		for (int i = 0; i < 9; i++) smp[i] <= SAMPLE_BITS'(s[i]);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_scan(s);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_fill(int unsigned v);
		int unsigned s[9];
		for (int i = 0; i < 9; i++) s[i] = v;
		send_scan(s);
	endtask

	task automatic send_random(int unsigned style);
		int unsigned s[9];
		int unsigned peak;
		peak = $urandom_range(0, 8);
		for (int i = 0; i < 9; i++) begin
			case (style)
				0: s[i] = $urandom_range(0, 1023);
				1: s[i] = (i == peak || i == peak + 1) ? $urandom_range(700, 1023)
					: $urandom_range(0, 200);
				default: s[i] = $urandom_range(0, 1) ? 1023 : 0;
			endcase
		end
		send_scan(s);
	endtask

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && n > 0) begin
				send_random($urandom_range(0, 4) < 3 ? 1 : $urandom_range(0, 2));
				burst--;
				n--;
			end
			if ($urandom_range(0, 1)) repeat ($urandom_range(1, 90)) @(negedge clk);
		end
	endtask

	initial begin
		int unsigned s[9];
		board = new();
		arst_n = 0;
		in_valid = 0;
		cfg_we = 0;
		cfg_index = REG_GAIN_P;
		cfg_data = 0;
		for (int i = 0; i < 9; i++) smp[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: flat channels at reset gains, then no signal and extremes
		send_fill(0);
		send_fill(1023);
		send_fill(1023);
		send_fill(0);
		for (int k = 0; k < 9; k++) begin
			for (int i = 0; i < 9; i++) s[i] = (i == k) ? 1023 : 0;
			send_scan(s);
		end
		drain();
		write_reg(REG_GAIN_P, 16'h7fff);
		write_reg(REG_GAIN_I, 16'h8000);
		write_reg(REG_GAIN_D, 16'h7fff);
		write_reg(REG_TARGET, 16'd1023);
		send_fill(512);
		for (int i = 0; i < 9; i++) s[i] = i * 100 + 50;
		send_scan(s);
		send_fill(0);
		drain();
		write_reg(REG_TARGET, 16'd0);
		write_reg(REG_GAIN_I, 16'h7fff);
		for (int i = 0; i < 9; i++) s[i] = (i == 8) ? 1023 : 0;
		repeat (4) send_scan(s);
		drain();

		// Random phases with varied gain settings
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_GAIN_P, 16'($urandom_range(0, 65535)));
			write_reg(REG_GAIN_I, (ph == 3) ? 16'h7fff : 16'($urandom_range(0, 65535)));
			write_reg(REG_GAIN_D, (ph == 5) ? 16'h8000 : 16'($urandom_range(0, 65535)));
			write_reg(REG_TARGET, (ph == 1) ? 16'd1000 : 16'($urandom_range(0, 1023)));
			random_phase(245);
			drain();
		end

		if (board.pending() == 0 && board.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* files.f */
design/lsp_pkg.sv
design/lsp_lane.sv
design/lsp_pid.sv
design/line_sensor_position_pid_top.sv
design/lsp_checker.sv
tb/sv/testbench.sv
